@@ hdl/pfl_pkg.sv @@
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared types and constants for the FIFO/LRU page replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pfl_pkg;

   // fixed field widths of the request and response
   localparam int unsigned REQ_PAGE_W = 16;
   localparam int unsigned SLOT_W     = 3;
   localparam int unsigned TOTAL_W    = 32;

   // policy register codes
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request page
      logic execute;   // look up, update table, load response register
   } pfl_cmd_type;

endpackage

`default_nettype wire

@@ hdl/pfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfl_ctrl
// Controller: sequences capture and execute steps and owns the response
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pfl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output pfl_pkg::pfl_cmd_type     cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   // response register can take a new result
   assign out_free = !out_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.execute  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

@@ hdl/pfl_datapath.sv @@
// ----------------------------------------------------------------------------
// pfl_datapath
// Page table as a row of registers with parallel compare and one-step shift,
// fault counter, policy register and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfl_datapath #(
   parameter int unsigned ENTRIES   = 8,
   parameter int unsigned PAGE_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pfl_pkg::pfl_cmd_type              cmd,
   input  wire logic [pfl_pkg::REQ_PAGE_W-1:0]    req_page_number,
   input  wire logic                              csr_write,
   input  wire logic                              csr_policy_mode,
   output logic                                   rsp_hit,
   output logic [pfl_pkg::SLOT_W-1:0]             rsp_slot,
   output logic [pfl_pkg::TOTAL_W-1:0]            rsp_miss_total
);

   localparam int unsigned IDX_W  = $clog2(ENTRIES);
   localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
   localparam int unsigned KEEP_W = (PAGE_BITS < pfl_pkg::REQ_PAGE_W) ?
                                    PAGE_BITS : pfl_pkg::REQ_PAGE_W;

   logic [PAGE_BITS-1:0]         page_ff, page_in;
   logic [PAGE_BITS-1:0]         table_ff [ENTRIES];
   logic [PAGE_BITS-1:0]         table_in [ENTRIES];
   logic [OCC_W-1:0]             occ_ff, occ_in;
   logic [pfl_pkg::TOTAL_W-1:0]  faults_ff, faults_in;
   logic                         policy_ff;
   logic [ENTRIES-1:0]           match;
   logic                         hit;
   logic [IDX_W-1:0]             hit_idx;
   logic [IDX_W-1:0]             last_idx;
   logic                         full;
   logic                         shift_en;
   logic [IDX_W-1:0]             shift_from;
   logic [IDX_W-1:0]             new_slot;
   logic                         hit_in;
   logic [pfl_pkg::SLOT_W-1:0]   slot_in;
   logic                         hit_ff;
   logic [pfl_pkg::SLOT_W-1:0]   slot_ff;

   // request page, low bits kept
   assign page_in = PAGE_BITS'(req_page_number[KEEP_W-1:0]);

   // parallel compare over occupied slots
   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         match[k] = (OCC_W'(k) < occ_ff) && (table_ff[k] == page_ff);
      end
   end

   // lowest matching slot
   always_comb begin
      hit_idx = '0;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (match[k]) begin
            hit_idx = IDX_W'(k);
         end
      end
   end

   assign hit      = |match;
   assign full     = (occ_ff == OCC_W'(ENTRIES));
   assign last_idx = IDX_W'(occ_ff - OCC_W'(1));

   // shift on an lru hit or a miss into a full table
   assign shift_en   = (hit && (policy_ff == pfl_pkg::POLICY_LRU)) || (!hit && full);
   assign shift_from = hit ? hit_idx : '0;

   // slot holding the page afterwards
   always_comb begin
      if (hit) begin
         new_slot = (policy_ff == pfl_pkg::POLICY_LRU) ? last_idx : hit_idx;
      end else if (full) begin
         new_slot = IDX_W'(ENTRIES - 1);
      end else begin
         new_slot = IDX_W'(occ_ff);
      end
   end

   // next table contents
   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         table_in[k] = table_ff[k];
         if (shift_en) begin
            if (IDX_W'(k) == last_idx) begin
               table_in[k] = page_ff;
            end else if ((IDX_W'(k) >= shift_from) && (IDX_W'(k) < last_idx) &&
                         (k < ENTRIES - 1)) begin
               table_in[k] = table_ff[(k + 1) % ENTRIES];
            end
         end else if (!hit && (OCC_W'(k) == occ_ff)) begin
            table_in[k] = page_ff;
         end
      end
   end

   // occupancy and saturating fault count
   always_comb begin
      occ_in    = occ_ff;
      faults_in = faults_ff;
      if (!hit) begin
         if (!full) begin
            occ_in = occ_ff + OCC_W'(1);
         end
         if (faults_ff != '1) begin
            faults_in = faults_ff + pfl_pkg::TOTAL_W'(1);
         end
      end
   end

   assign hit_in  = hit;
   assign slot_in = pfl_pkg::SLOT_W'(new_slot);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         faults_ff <= '0;
         policy_ff <= pfl_pkg::POLICY_FIFO;
      end else begin
         if (cmd.execute) begin
            occ_ff    <= occ_in;
            faults_ff <= faults_in;
         end
         if (csr_write) begin
            policy_ff <= csr_policy_mode;
         end
      end
   end

   // table, request and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff <= page_in;
      end
      if (cmd.execute) begin
         for (int k = 0; k < ENTRIES; k++) begin
            table_ff[k] <= table_in[k];
         end
         hit_ff  <= hit_in;
         slot_ff <= slot_in;
      end
   end

   assign rsp_hit        = hit_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_miss_total = faults_ff;

endmodule

`default_nettype wire

@@ hdl/page_replacement_fifo_lru_unit.sv @@
// Sequence: the request transfer captures the page; the execute step then looks
// up the page, updates the table and loads the response register.
// Flow: a new reference is taken only once the previous one has completed the
// compare-and-update step; a stalled response holds the update step.
// Reset: synchronous; empties the table, clears the fault count and selects
// first-in first-out. Table entries are not cleared; empty slots are never read.
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_unit
// Fully associative page table with FIFO or LRU replacement and fault count.
// ----------------------------------------------------------------------------
`default_nettype none

module page_replacement_fifo_lru_unit #(
   parameter int unsigned ENTRIES   = 8,
   parameter int unsigned PAGE_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [pfl_pkg::REQ_PAGE_W-1:0]    req_page_number,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_hit,
   output logic [pfl_pkg::SLOT_W-1:0]             rsp_slot,
   output logic [pfl_pkg::TOTAL_W-1:0]            rsp_miss_total,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic                              csr_policy_mode
);

   pfl_pkg::pfl_cmd_type cmd;

   // policy register always takes a transfer
   assign csr_ready = 1'b1;

   // controller
   pfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath
   pfl_datapath #(
      .ENTRIES   (ENTRIES),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_page_number (req_page_number),
      .csr_write       (csr_valid && csr_ready),
      .csr_policy_mode (csr_policy_mode),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_miss_total  (rsp_miss_total)
   );

endmodule

`default_nettype wire

@@ hdl/pfl_checker.sv @@
// ----------------------------------------------------------------------------
// pfl_checker
// Port-level checks for the page replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfl_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [pfl_pkg::REQ_PAGE_W-1:0]    req_page_number,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_hit,
   input wire logic [pfl_pkg::SLOT_W-1:0]        rsp_slot,
   input wire logic [pfl_pkg::TOTAL_W-1:0]       rsp_miss_total,
   input wire logic                              csr_valid,
   input wire logic                              csr_ready,
   input wire logic                              csr_policy_mode
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_slot) && $stable(rsp_miss_total))
      else $error("response changed while stalled");

   // one reference in flight: no transfer right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // a miss always shows a nonzero fault count
   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_miss_total != '0)
      else $error("miss reported with zero fault count");

   // a rising response valid must follow a request transfer
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a preceding request");

   // reset leaves no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind page_replacement_fifo_lru_unit pfl_checker u_pfl_checker (.*);

`default_nettype wire
